// File: design/nst_pkg.sv
`timescale 1ns / 1ps

package nst_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int MIN_ENTRIES = 5;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_W       = 7;
    localparam int ID_W        = 16;
    localparam int ADDR_W      = 32;
    localparam int PORT_W      = 16;
    localparam int OUT_ID_W    = 6;
    localparam int ENTRY_W     = ADDR_W + PORT_W;

    localparam logic [CFG_W-1:0] ENTRIES_RESET = CFG_W'(64);

    typedef enum logic [2:0] {
        CMD_ALLOC     = 3'd0,
        CMD_RELEASE   = 3'd1,
        CMD_QUERY     = 3'd2,
        CMD_FIND_ADDR = 3'd3,
        CMD_FIND_PORT = 3'd4
    } cmd_t;

    localparam logic REG_ENTRIES = 1'b0;

endpackage

// File: design/nst_ram.sv
`timescale 1ns / 1ps

module nst_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/neighbor_session_table_top.sv
`timescale 1ns / 1ps
// Allocate, release and any failure decided on the id go from execute to the result state; a
// successful query has a table read state in between; a find reads one entry per cycle, up to n
// entries, where n is entries_in_use limited to 64 and taken as 0 below 5.
// One item is processed at a time: the next input is accepted in the cycle after the result has
// been placed in the output register, which waits while an earlier result is still unaccepted.
// Reset clears all active flags and sets entries_in_use to 64; stored data needs no clearing.

module neighbor_session_table_top
    import nst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // entry_id, peer_address, peer_port
    input  logic [2:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // found_id, found_address, found_port, zero fill
    output logic        m_tuser,   // status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_QREAD,
        ST_SCAN,
        ST_RESULT
    } state_t;

    state_t                 state_reg, state_next;
    logic [CFG_W-1:0]       cfg_reg, cfg_next;
    logic [TABLE_DEPTH-1:0] active_reg, active_next;
    logic [2:0]             cmd_reg, cmd_next;
    logic [ID_W-1:0]        id_reg, id_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic [PORT_W-1:0]      port_reg, port_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   pend_reg, pend_next;
    logic [IDX_W-1:0]       pend_idx_reg, pend_idx_next;
    logic                   res_ok_reg, res_ok_next;
    logic [IDX_W-1:0]       res_id_reg, res_id_next;
    logic [ADDR_W-1:0]      res_addr_reg, res_addr_next;
    logic [PORT_W-1:0]      res_port_reg, res_port_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [55:0]            m_tdata_reg, m_tdata_next;
    logic                   m_tuser_reg, m_tuser_next;

    logic [CNT_W-1:0]   live_n;
    logic               id_ok;
    logic [IDX_W-1:0]   id_idx;
    logic               ram_we;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ADDR_W-1:0]  rd_addr;
    logic [PORT_W-1:0]  rd_port;
    logic               cfg_write;
    logic               scan_hit;

    nst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (id_idx),
        .wdata ({port_reg, addr_reg}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_addr = ram_rdata[ADDR_W-1:0];
    assign rd_port = ram_rdata[ENTRY_W-1:ADDR_W];

    always_comb
    begin
        if (cfg_reg < CFG_W'(MIN_ENTRIES))
        begin
            live_n = '0;
        end
        else if (cfg_reg > CFG_W'(TABLE_DEPTH))
        begin
            live_n = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            live_n = CNT_W'(cfg_reg);
        end
    end

    assign id_idx = id_reg[IDX_W-1:0];
    assign id_ok  = id_reg < ID_W'(live_n);

    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_ENTRIES);
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_ENTRIES) ? {{(32-CFG_W){1'b0}}, cfg_reg} : 32'd0;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign scan_hit = pend_reg && active_reg[pend_idx_reg] &&
                      ((cmd_reg == CMD_FIND_ADDR) ? (rd_addr == addr_reg)
                                                  : (rd_port == port_reg));

    always_comb
    begin
        state_next    = state_reg;
        cfg_next      = cfg_write ? pwdata[CFG_W-1:0] : cfg_reg;
        active_next   = active_reg;
        cmd_next      = cmd_reg;
        id_next       = id_reg;
        addr_next     = addr_reg;
        port_next     = port_reg;
        cnt_next      = cnt_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        res_ok_next   = res_ok_reg;
        res_id_next   = res_id_reg;
        res_addr_next = res_addr_reg;
        res_port_next = res_port_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_raddr     = id_idx;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tuser;
                    id_next    = s_tdata[ID_W-1:0];
                    addr_next  = s_tdata[ID_W+ADDR_W-1:ID_W];
                    port_next  = s_tdata[ID_W+ADDR_W+PORT_W-1:ID_W+ADDR_W];
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_ok_next   = 1'b0;
                res_id_next   = id_idx;
                res_addr_next = '0;
                res_port_next = '0;
                state_next    = ST_RESULT;
                case (cmd_reg)
                    CMD_ALLOC:
                    begin
                        if (id_ok && !active_reg[id_idx])
                        begin
                            ram_we              = 1'b1;
                            active_next[id_idx] = 1'b1;
                            res_ok_next         = 1'b1;
                            res_addr_next       = addr_reg;
                            res_port_next       = port_reg;
                        end
                    end
                    CMD_RELEASE:
                    begin
                        if (id_ok && active_reg[id_idx])
                        begin
                            active_next[id_idx] = 1'b0;
                            res_ok_next         = 1'b1;
                        end
                    end
                    CMD_QUERY:
                    begin
                        if (id_ok && active_reg[id_idx])
                        begin
                            ram_re     = 1'b1;
                            state_next = ST_QREAD;
                        end
                    end
                    CMD_FIND_ADDR, CMD_FIND_PORT:
                    begin
                        cnt_next   = live_n;
                        state_next = ST_SCAN;
                    end
                    default:
                    begin
                        res_ok_next = 1'b0;
                    end
                endcase
            end
            ST_QREAD:
            begin
                res_ok_next   = 1'b1;
                res_addr_next = rd_addr;
                res_port_next = rd_port;
                state_next    = ST_RESULT;
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    res_ok_next   = 1'b1;
                    res_id_next   = pend_idx_reg;
                    res_addr_next = rd_addr;
                    res_port_next = rd_port;
                    state_next    = ST_RESULT;
                end
                else if (cnt_reg != '0)
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = IDX_W'(cnt_reg - CNT_W'(1));
                    pend_next     = 1'b1;
                    pend_idx_next = IDX_W'(cnt_reg - CNT_W'(1));
                    cnt_next      = cnt_reg - CNT_W'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = !res_ok_reg;
                    if (res_ok_reg)
                    begin
                        m_tdata_next = {2'b00, res_port_reg, res_addr_reg,
                                        OUT_ID_W'(res_id_reg)};
                    end
                    else
                    begin
                        m_tdata_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cfg_reg      <= ENTRIES_RESET;
            active_reg   <= '0;
            cmd_reg      <= '0;
            id_reg       <= '0;
            addr_reg     <= '0;
            port_reg     <= '0;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
            res_ok_reg   <= 1'b0;
            res_id_reg   <= '0;
            res_addr_reg <= '0;
            res_port_reg <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cfg_reg      <= cfg_next;
            active_reg   <= active_next;
            cmd_reg      <= cmd_next;
            id_reg       <= id_next;
            addr_reg     <= addr_next;
            port_reg     <= port_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            pend_idx_reg <= pend_idx_next;
            res_ok_reg   <= res_ok_next;
            res_id_reg   <= res_id_next;
            res_addr_reg <= res_addr_next;
            res_port_reg <= res_port_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
        end
    end

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("Input accepted while an item was in progress.");

    a_result_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && res_ok_reg && cmd_reg != CMD_RELEASE)
            |-> active_reg[res_id_reg])
        else $error("Successful result refers to an inactive entry.");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("Failure result carries non-zero data.");

    a_read_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (state_reg == ST_EXEC || state_reg == ST_SCAN))
        else $error("Table read issued outside query or scan.");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import nst_pkg::*;

    localparam int LIMIT_CYCLES = 800000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = TABLE_DEPTH + 16;
    localparam int IDLE_PERCENT = 38;
    localparam logic [2:0] CMD_UNKNOWN = 3'(CMD_FIND_PORT + 1);
    localparam logic [2:0] CMD_LAST = 3'b111;
    localparam logic [2:0] ENTRIES_ADDR = {2'b00, REG_ENTRIES} << 2;

    typedef struct {
        logic [2:0]        cmd;
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
    } table_cmd_t;

    typedef struct {
        logic                status;
        logic [OUT_ID_W-1:0] id;
        logic [ADDR_W-1:0]   addr;
        logic [PORT_W-1:0]   port;
    } table_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // entry_id, peer_address, peer_port
    logic [2:0]  s_tuser = '0;   // command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;        // found_id, found_address, found_port, zero fill
    logic        m_tuser;        // status
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic              table_active [TABLE_DEPTH];
    logic [ADDR_W-1:0] table_addr [TABLE_DEPTH];
    logic [PORT_W-1:0] table_port [TABLE_DEPTH];
    logic [CFG_W-1:0]  entries_cfg = ENTRIES_RESET;

    logic [ADDR_W-1:0] addr_pool [8];
    logic [PORT_W-1:0] port_pool [8];

    table_cmd_t   pending_cmds [$];
    table_reply_t expected_replies [$];
    table_cmd_t   on_bus;
    table_reply_t want;

    int  accepted_items = 0;
    int  fail_count = 0;
    int  cycle_count = 0;
    int  rx_hold_left = 0;
    int  held_at = -1;
    logic calm;

    assign calm = (accepted_items >= 600) && (accepted_items < 800);

    neighbor_session_table_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        fail_count++;
    endtask

    function automatic table_reply_t apply_command(input table_cmd_t c);
        table_reply_t r;
        int live;
        bit id_ok;
        bit hit;
        int slot;
        live = (entries_cfg < MIN_ENTRIES) ? 0 :
               (entries_cfg > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries_cfg);
        id_ok = c.id < live;
        hit = 1'b0;
        slot = 0;
        case (c.cmd)
            CMD_ALLOC:
            begin
                if (id_ok && !table_active[c.id])
                begin
                    table_active[c.id] = 1'b1;
                    table_addr[c.id] = c.addr;
                    table_port[c.id] = c.port;
                    hit = 1'b1;
                    slot = c.id;
                end
            end
            CMD_RELEASE:
            begin
                if (id_ok && table_active[c.id])
                begin
                    table_active[c.id] = 1'b0;
                    table_addr[c.id] = '0;
                    table_port[c.id] = '0;
                    hit = 1'b1;
                    slot = c.id;
                end
            end
            CMD_QUERY:
            begin
                if (id_ok && table_active[c.id])
                begin
                    hit = 1'b1;
                    slot = c.id;
                end
            end
            CMD_FIND_ADDR, CMD_FIND_PORT:
            begin
                for (int k = live - 1; k >= 0 && !hit; k--)
                begin
                    if (table_active[k] && ((c.cmd == CMD_FIND_ADDR) ?
                        (table_addr[k] == c.addr) : (table_port[k] == c.port)))
                    begin
                        hit = 1'b1;
                        slot = k;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.status = !hit;
        r.id = hit ? OUT_ID_W'(slot) : '0;
        r.addr = hit ? table_addr[slot] : '0;
        r.port = hit ? table_port[slot] : '0;
        return r;
    endfunction

    function automatic table_cmd_t random_cmd(input int span);
        table_cmd_t c;
        int pick;
        pick = $urandom_range(0, 99);
        c.id = ID_W'($urandom_range(0, span + 1));
        c.addr = ($urandom_range(0, 9) < 7) ? addr_pool[$urandom_range(0, 7)] : $urandom;
        c.port = ($urandom_range(0, 9) < 7) ? port_pool[$urandom_range(0, 7)]
                                             : PORT_W'($urandom);
        if (pick < 30)
            c.cmd = CMD_ALLOC;
        else if (pick < 48)
            c.cmd = CMD_RELEASE;
        else if (pick < 64)
            c.cmd = CMD_QUERY;
        else if (pick < 79)
            c.cmd = CMD_FIND_ADDR;
        else if (pick < 94)
            c.cmd = CMD_FIND_PORT;
        else if (pick < 97)
            c.cmd = 3'($urandom_range(int'(CMD_UNKNOWN), int'(CMD_LAST)));
        else
        begin
            c.cmd = 3'($urandom);
            c.id = ID_W'($urandom);
        end
        return c;
    endfunction

    task automatic queue_cmd(input logic [2:0] cmd, input int id,
                             input logic [ADDR_W-1:0] addr, input logic [PORT_W-1:0] port);
        table_cmd_t c;
        c.cmd = cmd;
        c.id = ID_W'(id);
        c.addr = addr;
        c.port = port;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || s_tvalid || expected_replies.size() != 0);
    endtask

    task automatic write_entries(input logic [CFG_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ENTRIES_ADDR;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        entries_cfg = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] value, input int items);
        int span;
        wait_idle();
        write_entries(value);
        span = (value > TABLE_DEPTH) ? TABLE_DEPTH :
               (value < MIN_ENTRIES) ? MIN_ENTRIES + 1 : int'(value);
        @(negedge clk);
        repeat (items)
            pending_cmds.push_back(random_cmd(span));
    endtask

    initial
    begin
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            table_active[k] = 1'b0;
            table_addr[k] = '0;
            table_port[k] = '0;
        end
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        port_pool[0] = '0;
        port_pool[1] = '1;
        for (int k = 2; k < 8; k++)
        begin
            addr_pool[k] = $urandom;
            port_pool[k] = PORT_W'($urandom);
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        write_entries(CFG_W'(TABLE_DEPTH));
        @(negedge clk);
        queue_cmd(CMD_ALLOC, 0, '0, '0);
        queue_cmd(CMD_ALLOC, TABLE_DEPTH - 1, '1, '1);
        queue_cmd(CMD_ALLOC, TABLE_DEPTH - 1, 32'h1234_5678, 16'h00ff);
        queue_cmd(CMD_ALLOC, TABLE_DEPTH, 32'h1, 16'h1);
        queue_cmd(CMD_ALLOC, 65535, '1, '1);
        queue_cmd(CMD_QUERY, TABLE_DEPTH - 1, '0, '0);
        queue_cmd(CMD_QUERY, 1, '0, '0);
        queue_cmd(CMD_QUERY, TABLE_DEPTH, '0, '0);
        queue_cmd(CMD_FIND_ADDR, 0, '1, '0);
        queue_cmd(CMD_FIND_ADDR, 0, '0, '0);
        queue_cmd(CMD_FIND_PORT, 0, '1, '0);
        queue_cmd(CMD_ALLOC, 5, '1, '0);
        queue_cmd(CMD_FIND_ADDR, 0, '1, '1);
        queue_cmd(CMD_FIND_PORT, 0, '1, '0);
        queue_cmd(CMD_RELEASE, TABLE_DEPTH - 1, '0, '0);
        queue_cmd(CMD_RELEASE, TABLE_DEPTH - 1, '0, '0);
        queue_cmd(CMD_QUERY, TABLE_DEPTH - 1, '0, '0);
        queue_cmd(CMD_FIND_ADDR, 0, '1, '0);
        queue_cmd(CMD_FIND_PORT, 0, '0, '1);
        queue_cmd(CMD_UNKNOWN, 0, '1, '1);
        queue_cmd(CMD_UNKNOWN + 3'd1, 5, '0, '0);
        queue_cmd(CMD_LAST, 5, '1, '0);
        queue_cmd(CMD_RELEASE, 0, '1, '1);
        queue_cmd(CMD_RELEASE, 65535, '0, '0);
        queue_cmd(CMD_QUERY, 5, '0, '0);

        run_phase(CFG_W'(MIN_ENTRIES), 60);
        run_phase('1, 300);
        run_phase(CFG_W'(20), 250);
        run_phase(CFG_W'(MIN_ENTRIES - 1), 25);
        run_phase('0, 15);
        run_phase(CFG_W'(TABLE_DEPTH), 300);
        run_phase(CFG_W'($urandom_range(MIN_ENTRIES, TABLE_DEPTH)), 200);
        run_phase(CFG_W'($urandom), 130);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_replies.push_back(apply_command(on_bus));
                accepted_items <= accepted_items + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_cmds.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PERCENT))
                begin
                    on_bus = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {on_bus.port, on_bus.addr, on_bus.id};
                    s_tuser <= on_bus.cmd;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1;
        else if ((accepted_items == 400 || accepted_items == 950) && held_at != accepted_items)
        begin
            rx_hold_left <= HOLD_CYCLES;
            held_at <= accepted_items;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_replies.size() == 0)
                begin
                    report_mismatch("result transfer with nothing expected");
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch($sformatf("status %0b, expected %0b",
                                                  m_tuser, want.status));
                    if (m_tdata[OUT_ID_W-1:0] !== want.id)
                        report_mismatch($sformatf("found_id %0d, expected %0d",
                                                  m_tdata[OUT_ID_W-1:0], want.id));
                    if (m_tdata[OUT_ID_W +: ADDR_W] !== want.addr)
                        report_mismatch($sformatf("found_address %h, expected %h",
                                                  m_tdata[OUT_ID_W +: ADDR_W], want.addr));
                    if (m_tdata[OUT_ID_W + ADDR_W +: PORT_W] !== want.port)
                        report_mismatch($sformatf("found_port %h, expected %h",
                                                  m_tdata[OUT_ID_W + ADDR_W +: PORT_W],
                                                  want.port));
                end
            end
            m_tready <= (rx_hold_left == 0) && (calm || $urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

endmodule

// File: filelist.f
design/nst_pkg.sv
design/nst_ram.sv
design/neighbor_session_table_top.sv
verif/testbench.sv
